// ===== design/nnis_pkg.sv =====
// Shared types and constants for the nearest-neighbor image scaler.
// Used by the front end, the request queue, the back end and the top level.
// No dependencies.
`default_nettype none

package nnis_pkg;

	// Default values of the top-level parameters.
	localparam int unsigned STORE_WORDS_DEF    = 262144;
	localparam int unsigned MAX_ROW_PIXELS_DEF = 4096;
	localparam int unsigned PIXEL_BITS_DEF     = 32;

	// Queue geometry and the widest store address any legal setting needs.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QADDR_W     = 24;

	// Request kinds on the input stream.
	localparam logic [1:0] REQ_WRITE   = 2'd0;
	localparam logic [1:0] REQ_NEXT    = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd0;
	localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd1;
	localparam logic [2:0] REG_OUTPUT_WIDTH  = 3'd2;
	localparam logic [2:0] REG_OUTPUT_HEIGHT = 3'd3;
	localparam logic [2:0] REG_COLUMN_STEP   = 3'd4;
	localparam logic [2:0] REG_ROW_STEP      = 3'd5;
	localparam logic [2:0] REG_COLUMN_START  = 3'd6;
	localparam logic [2:0] REG_ROW_START     = 3'd7;

	// Reset values of the configuration registers.
	localparam logic [12:0] SOURCE_WIDTH_RST  = 13'd1;
	localparam logic [12:0] SOURCE_HEIGHT_RST = 13'd1;
	localparam logic [12:0] OUTPUT_WIDTH_RST  = 13'd0;
	localparam logic [12:0] OUTPUT_HEIGHT_RST = 13'd0;
	localparam logic [31:0] STEP_RST          = 32'd65536;
	localparam logic [31:0] START_RST         = 32'd32768;

	// Operations handed from the front end to the back end.
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_ZERO  = 2'd2;

	// One queued operation: a store write, a store read or a zero-pixel result.
	typedef struct packed {
		logic [1:0]         op;
		logic [QADDR_W-1:0] addr;
		logic [31:0]        data;
		logic [11:0]        col;
		logic [11:0]        row;
		logic               last;
		logic               fin;
	} nnis_entry_t;

endpackage

`default_nettype wire

// ===== design/nnis_front.sv =====
// Front end of the scaler: configuration registers, request decode and the
// row/column accumulators. Produces store operations for the queue.
// Depends on nnis_pkg.
`default_nettype none

module nnis_front #(
	parameter int unsigned STORE_WORDS    = nnis_pkg::STORE_WORDS_DEF,
	parameter int unsigned MAX_ROW_PIXELS = nnis_pkg::MAX_ROW_PIXELS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [2:0]           cfg_index,
	input  wire logic [31:0]          cfg_wdata,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [1:0]           req_type,
	input  wire logic [17:0]          write_address,
	input  wire logic [31:0]          write_pixel,
	output logic                      push,
	output nnis_pkg::nnis_entry_t     push_entry,
	input  wire logic                 queue_full
);

	localparam int unsigned MAXW = (MAX_ROW_PIXELS > 8191) ? 8191 : MAX_ROW_PIXELS;
	localparam logic [12:0] MAX_ROW_W = 13'(MAXW);

	logic [12:0] source_width_q, source_height_q, output_width_q, output_height_q;
	logic [31:0] column_step_q, row_step_q, column_start_q, row_start_q;
	logic [31:0] col_acc_q, row_acc_q;
	logic [11:0] col_cnt_q;
	logic [12:0] row_cnt_q;
	logic        fin_q;

	logic        accept;
	logic [12:0] eff_width, width_eff, max_col, src_col;
	logic [15:0] src_row, src_col_raw;
	logic [28:0] prod;
	logic [29:0] rd_addr;
	logic        rd_in_range, wr_in_range, frame_end, last;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_width_q  <= nnis_pkg::SOURCE_WIDTH_RST;
			source_height_q <= nnis_pkg::SOURCE_HEIGHT_RST;
			output_width_q  <= nnis_pkg::OUTPUT_WIDTH_RST;
			output_height_q <= nnis_pkg::OUTPUT_HEIGHT_RST;
			column_step_q   <= nnis_pkg::STEP_RST;
			row_step_q      <= nnis_pkg::STEP_RST;
			column_start_q  <= nnis_pkg::START_RST;
			row_start_q     <= nnis_pkg::START_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				nnis_pkg::REG_SOURCE_WIDTH:  source_width_q  <= cfg_wdata[12:0];
				nnis_pkg::REG_SOURCE_HEIGHT: source_height_q <= cfg_wdata[12:0];
				nnis_pkg::REG_OUTPUT_WIDTH:  output_width_q  <= cfg_wdata[12:0];
				nnis_pkg::REG_OUTPUT_HEIGHT: output_height_q <= cfg_wdata[12:0];
				nnis_pkg::REG_COLUMN_STEP:   column_step_q   <= cfg_wdata;
				nnis_pkg::REG_ROW_STEP:      row_step_q      <= cfg_wdata;
				nnis_pkg::REG_COLUMN_START:  column_start_q  <= cfg_wdata;
				nnis_pkg::REG_ROW_START:     row_start_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Source row, clamped source column, read address and end checks.
	always_comb begin
		eff_width   = (output_width_q > MAX_ROW_W) ? MAX_ROW_W : output_width_q;
		width_eff   = (source_width_q == 13'd0) ? 13'd1 : source_width_q;
		max_col     = width_eff - 13'd1;
		src_row     = row_acc_q[31:16];
		src_col_raw = col_acc_q[31:16];
		src_col     = (src_col_raw > {3'b000, max_col}) ? max_col : src_col_raw[12:0];
		prod        = 29'(src_row) * 29'(width_eff);
		rd_addr     = 30'(prod) + 30'(src_col);
		rd_in_range = rd_addr < 30'(STORE_WORDS);
		wr_in_range = 32'(write_address) < 32'(STORE_WORDS);
		frame_end   = fin_q || (eff_width == 13'd0) || (output_height_q == 13'd0) ||
			(row_cnt_q >= output_height_q) || (src_row >= {3'b000, source_height_q});
		last        = ({1'b0, col_cnt_q} + 13'd1) >= eff_width;
	end

	// Build the queued operation for the accepted request.
	always_comb begin
		push       = 1'b0;
		push_entry = '0;
		if (accept) begin
			unique case (req_type)
				nnis_pkg::REQ_WRITE: begin
					push            = wr_in_range;
					push_entry.op   = nnis_pkg::OP_WRITE;
					push_entry.addr = nnis_pkg::QADDR_W'(write_address);
					push_entry.data = write_pixel;
				end
				nnis_pkg::REQ_NEXT: begin
					push = 1'b1;
					if (frame_end) begin
						push_entry.op  = nnis_pkg::OP_ZERO;
						push_entry.fin = 1'b1;
					end else begin
						push_entry.op   = rd_in_range ? nnis_pkg::OP_READ : nnis_pkg::OP_ZERO;
						push_entry.addr = rd_addr[nnis_pkg::QADDR_W-1:0];
						push_entry.col  = col_cnt_q;
						push_entry.row  = row_cnt_q[11:0];
						push_entry.last = last;
					end
				end
				default: ;
			endcase
		end
	end

	// Accumulators, counters and the frame-finished flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_acc_q <= nnis_pkg::START_RST;
			row_acc_q <= nnis_pkg::START_RST;
			col_cnt_q <= '0;
			row_cnt_q <= '0;
			fin_q     <= 1'b0;
		end else if (accept) begin
			if (req_type == nnis_pkg::REQ_RESTART) begin
				col_acc_q <= column_start_q;
				row_acc_q <= row_start_q;
				col_cnt_q <= '0;
				row_cnt_q <= '0;
				fin_q     <= 1'b0;
			end else if (req_type == nnis_pkg::REQ_NEXT) begin
				if (frame_end) begin
					fin_q <= 1'b1;
				end else if (last) begin
					col_cnt_q <= '0;
					col_acc_q <= column_start_q;
					row_acc_q <= row_acc_q + row_step_q;
					row_cnt_q <= row_cnt_q + 13'd1;
				end else begin
					col_cnt_q <= col_cnt_q + 12'd1;
					col_acc_q <= col_acc_q + column_step_q;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/nnis_queue.sv =====
// Short first-in first-out queue of store operations between the front end
// and the back end. Depends on nnis_pkg.
`default_nettype none

module nnis_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire nnis_pkg::nnis_entry_t push_entry,
	output logic                      full,
	output logic                      head_valid,
	output nnis_pkg::nnis_entry_t     head_entry,
	input  wire logic                 pop
);

	localparam int unsigned PTR_W = $clog2(nnis_pkg::QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(nnis_pkg::QUEUE_DEPTH + 1);

	nnis_pkg::nnis_entry_t slots_q [nnis_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = count_q == CNT_W'(nnis_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_entry = slots_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(nnis_pkg::QUEUE_DEPTH - 1)) ? '0 :
					wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(nnis_pkg::QUEUE_DEPTH - 1)) ? '0 :
					rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// A push lands on a full queue only together with a pop, and a pop never drains an empty one.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop)) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("queue pop while empty");

endmodule

`default_nettype wire

// ===== design/nnis_back.sv =====
// Back end of the scaler: the source image store, the registered read stage
// and the output register. Depends on nnis_pkg.
`default_nettype none

module nnis_back #(
	parameter int unsigned STORE_WORDS = nnis_pkg::STORE_WORDS_DEF,
	parameter int unsigned PIXEL_BITS  = nnis_pkg::PIXEL_BITS_DEF,
	parameter int unsigned ADDR_W      = $clog2(STORE_WORDS)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 head_valid,
	input  wire nnis_pkg::nnis_entry_t head_entry,
	output logic                      pop,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [31:0]               out_pixel,
	output logic [11:0]               out_column,
	output logic [11:0]               out_row,
	output logic                      out_last,
	output logic                      out_fin
);

	localparam int unsigned STORE_BITS = (PIXEL_BITS > 32) ? 32 : PIXEL_BITS;

	logic [STORE_BITS-1:0] store_q [STORE_WORDS];
	logic [STORE_BITS-1:0] rd_data_q;

	logic        s1_v, s1_zero, s1_last, s1_fin;
	logic [11:0] s1_col, s1_row;
	logic        s1_adv, is_write, mem_we, mem_re;

	logic        out_v_q, out_last_q, out_fin_q;
	logic [31:0] out_pixel_q;
	logic [11:0] out_col_q, out_row_q;

	// Pop a write at once; a read or a zero result needs a free read stage.
	assign is_write = head_entry.op == nnis_pkg::OP_WRITE;
	assign s1_adv   = s1_v && (!out_v_q || out_ready);
	assign pop      = head_valid && (is_write || !s1_v || s1_adv);
	assign mem_we   = pop && is_write;
	assign mem_re   = pop && (head_entry.op == nnis_pkg::OP_READ);

	// Image store: one write or one read per cycle as the queue head is popped, read data registered.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[head_entry.addr[ADDR_W-1:0]] <= head_entry.data[STORE_BITS-1:0];
		end
		if (mem_re) begin
			rd_data_q <= store_q[head_entry.addr[ADDR_W-1:0]];
		end
	end

	// Read stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (pop && !is_write) begin
			s1_v <= 1'b1;
		end else if (s1_adv) begin
			s1_v <= 1'b0;
		end
	end

	// Read stage result fields travel beside the store read.
	always_ff @(posedge clk) begin
		if (pop && !is_write) begin
			s1_zero <= head_entry.op != nnis_pkg::OP_READ;
			s1_col  <= head_entry.col;
			s1_row  <= head_entry.row;
			s1_last <= head_entry.last;
			s1_fin  <= head_entry.fin;
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_adv) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_pixel_q <= s1_zero ? 32'd0 : 32'(rd_data_q);
			out_col_q   <= s1_col;
			out_row_q   <= s1_row;
			out_last_q  <= s1_last;
			out_fin_q   <= s1_fin;
		end
	end

	assign out_valid  = out_v_q;
	assign out_pixel  = out_pixel_q;
	assign out_column = out_col_q;
	assign out_row    = out_row_q;
	assign out_last   = out_last_q;
	assign out_fin    = out_fin_q;

	// A new read never lands on a read stage that is still holding its result.
	a_s1_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !is_write) |-> (!s1_v || s1_adv)) else $error("read stage overwritten");
	// A result leaving the read stage always shows up in the output register.
	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> out_v_q) else $error("result lost between read stage and output");
	// A finished-frame result carries no pixel and no row end.
	a_fin_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_fin_q) |-> (out_pixel_q == 32'd0 && !out_last_q))
		else $error("finished result carries data");

endmodule

`default_nettype wire

// ===== design/nearest_neighbor_image_scaler_unit.sv =====
// Path: an accepted next request passes through the queue, then the store read
// stage, then the output register.
// Throughput: one request per cycle, set by the single store port that takes
// one write or one read each cycle; a stalled output backs up through the queue.
// Reset: arst_n clears control state and loads register reset values; the
// image store is not cleared and reads back undefined until written.
`default_nettype none

module nearest_neighbor_image_scaler_unit #(
	parameter int unsigned STORE_WORDS    = nnis_pkg::STORE_WORDS_DEF,
	parameter int unsigned MAX_ROW_PIXELS = nnis_pkg::MAX_ROW_PIXELS_DEF,
	parameter int unsigned PIXEL_BITS     = nnis_pkg::PIXEL_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [55:0] s_axis_tdata,  // write_address[17:0], write_pixel[49:18]
	input  wire logic [1:0]  s_axis_tuser,  // req_type[1:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [55:0]      m_axis_tdata,  // pixel[31:0], out_column[43:32], out_row[55:44]
	output logic             m_axis_tlast,  // row_last
	output logic             m_axis_tuser   // frame_finished
);

	localparam int unsigned ADDR_W = $clog2(STORE_WORDS);

	logic                  push, queue_full, head_valid, pop;
	nnis_pkg::nnis_entry_t push_entry, head_entry;
	logic [31:0]           out_pixel;
	logic [11:0]           out_column, out_row;
	logic [5:0]            unused_pad;

	// Padding bits of the input request carry nothing.
	assign unused_pad = s_axis_tdata[55:50];

	// Front end: decode requests and step the sampling position.
	nnis_front #(
		.STORE_WORDS    (STORE_WORDS),
		.MAX_ROW_PIXELS (MAX_ROW_PIXELS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.req_type      (s_axis_tuser),
		.write_address (s_axis_tdata[17:0]),
		.write_pixel   (s_axis_tdata[49:18]),
		.push          (push),
		.push_entry    (push_entry),
		.queue_full    (queue_full)
	);

	// Queue between the two halves.
	nnis_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop)
	);

	// Back end: image store and output register.
	nnis_back #(
		.STORE_WORDS (STORE_WORDS),
		.PIXEL_BITS  (PIXEL_BITS),
		.ADDR_W      (ADDR_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_pixel  (out_pixel),
		.out_column (out_column),
		.out_row    (out_row),
		.out_last   (m_axis_tlast),
		.out_fin    (m_axis_tuser)
	);

	assign m_axis_tdata = {out_row, out_column, out_pixel};

endmodule

`default_nettype wire
